// ----- rtl/core/life_generation_with_ages_top_assert.svh -----
// Assertion macros for the life generation core.
// Included by the queue, front and back modules; needs clk and rst_n in scope.
`ifndef LIFE_GENERATION_WITH_AGES_TOP_ASSERT_SVH
`define LIFE_GENERATION_WITH_AGES_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LGWA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lgwa assertion failed");

// Next-cycle implication, disabled during reset.
`define LGWA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lgwa assertion failed");

`endif

// ----- rtl/core/lgwa_pkg.sv -----
// Shared types and constants of the life generation core.
// Used by the queue, front, back and top modules; depends on nothing.
package lgwa_pkg;

  localparam int AGE_W      = 8;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 5;
  localparam int ROWS_REG_W = 11;
  localparam int COLS_REG_W = 6;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [1:0] REG_GRID_COLS = 2'd1;
  localparam logic [1:0] REG_MAX_AGE   = 2'd2;

  localparam logic [ROWS_REG_W-1:0] ROWS_RESET    = 11'd32;
  localparam logic [COLS_REG_W-1:0] COLS_RESET    = 6'd32;
  localparam logic [AGE_W-1:0]      MAX_AGE_RESET = 8'd255;

  localparam logic [3:0] CNT_SURVIVE = 4'd2;
  localparam logic [3:0] CNT_BIRTH   = 4'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam logic [QPTR_W:0] Q_FULL_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

  typedef struct packed {
    logic             emit;
    logic             top_off;
    logic             bot_off;
    logic             left_off;
    logic             right_off;
    logic             done;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } step_info_t;

  // One record per raster step: the newest column of live bits (top, middle,
  // bottom), the age one row above the newest cell and the result's position.
  typedef struct packed {
    logic [2:0]       nbr_col;
    logic [AGE_W-1:0] age;
    step_info_t       info;
  } lgwa_rec_t;

endpackage

// ----- rtl/core/lgwa_queue.sv -----
// Short FIFO of step records between the front and the back.
// Depends on lgwa_pkg and the assertion macro header.
`include "life_generation_with_ages_top_assert.svh"

module lgwa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lgwa_pkg::lgwa_rec_t wdata,
  input  logic                pop,
  output lgwa_pkg::lgwa_rec_t rdata,
  output logic                full,
  output logic                empty
);

  lgwa_pkg::lgwa_rec_t entries_r [lgwa_pkg::QUEUE_DEPTH];
  logic [lgwa_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lgwa_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lgwa_pkg::QPTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == lgwa_pkg::Q_FULL_CNT);
  assign empty = (cnt_r == '0);
  assign rdata = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + lgwa_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + lgwa_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (lgwa_pkg::QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (lgwa_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

  `LGWA_ASSERT_IMPL(a_no_overflow, push, !full)
  `LGWA_ASSERT_IMPL(a_no_underflow, pop, !empty)

endmodule

// ----- rtl/core/lgwa_front.sv -----
// Front of the life generation core: raster counters, frame drain, line buffers.
// Depends on lgwa_pkg and the assertion macro header; feeds lgwa_queue.
`include "life_generation_with_ages_top_assert.svh"

module lgwa_front #(
  parameter int  MAX_COLS = 32,
  parameter int  MAX_ROWS = 1024,
  localparam int RW       = $clog2(MAX_ROWS + 2),
  localparam int CW       = $clog2(MAX_COLS + 1),
  localparam int CIW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic [RW-1:0]                rows_eff,
  input  logic [CW-1:0]                cols_eff,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lgwa_pkg::AGE_W-1:0]   in_cell_age,
  input  logic                         q_full,
  output logic                         q_push,
  output lgwa_pkg::lgwa_rec_t          q_wdata
);

  logic [RW-1:0]  row_r, row_nxt;
  logic [CIW-1:0] col_r, col_nxt;
  logic           drain_r, drain_nxt;
  logic           s1_v_r, s1_v_nxt;
  lgwa_pkg::step_info_t s1_info_r;
  logic [CIW-1:0] s1_col_r;
  logic           s1_alive_r;
  logic           fwd_r;
  logic           fwd_val_r;

  logic [lgwa_pkg::AGE_W-1:0] age_line_r [MAX_COLS];
  logic                       alive_line_r [MAX_COLS];
  logic [lgwa_pkg::AGE_W-1:0] age_rd_r;
  logic                       alive_rd_r;

  logic [CIW-1:0] last_col;
  logic [RW-1:0]  rows_m1, rows_p1;
  logic           s1_free, real_step, step, final_step, last_real;
  logic [lgwa_pkg::AGE_W-1:0] step_age;
  logic [RW-1:0]  res_row;
  logic [CIW-1:0] res_col;
  lgwa_pkg::step_info_t step_info;

  assign last_col   = CIW'(cols_eff - CW'(1));
  assign rows_m1    = rows_eff - RW'(1);
  assign rows_p1    = rows_eff + RW'(1);
  assign s1_free    = !s1_v_r || !q_full;
  assign q_push     = s1_v_r && !q_full;
  assign in_stall   = drain_r || !s1_free;
  assign real_step  = in_valid && !in_stall;
  assign step       = real_step || (drain_r && s1_free);
  assign step_age   = drain_r ? '0 : in_cell_age;
  assign final_step = drain_r && (row_r == rows_p1);
  assign last_real  = !drain_r && (row_r == rows_m1) && (col_r == last_col);

  always_comb begin
    if (col_r != '0) begin
      res_row = row_r - RW'(1);
      res_col = col_r - CIW'(1);
    end else begin
      res_row = row_r - RW'(2);
      res_col = last_col;
    end
    step_info.emit      = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
    step_info.top_off   = (res_row == '0);
    step_info.bot_off   = (res_row == rows_m1);
    step_info.left_off  = (res_col == '0);
    step_info.right_off = (res_col == last_col);
    step_info.done      = final_step;
    step_info.row       = lgwa_pkg::ROW_W'(res_row);
    step_info.col       = lgwa_pkg::COL_W'(res_col);
  end

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    drain_nxt = drain_r;
    if (restart) begin
      row_nxt   = '0;
      col_nxt   = '0;
      drain_nxt = 1'b0;
    end else if (step) begin
      if (final_step) begin
        row_nxt   = '0;
        col_nxt   = '0;
        drain_nxt = 1'b0;
      end else begin
        if (col_r == last_col) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + CIW'(1);
        end
        if (last_real) begin
          drain_nxt = 1'b1;
        end
      end
    end
    s1_v_nxt = step ? 1'b1 : (q_push ? 1'b0 : s1_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      drain_r <= 1'b0;
      s1_v_r  <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      drain_r <= drain_nxt;
      s1_v_r  <= s1_v_nxt;
      if (step) begin
        fwd_r <= q_push && (s1_col_r == col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_info_r  <= step_info;
      s1_col_r   <= col_r;
      s1_alive_r <= (step_age != '0);
      fwd_val_r  <= (age_rd_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      age_rd_r          <= age_line_r[col_r];
      age_line_r[col_r] <= step_age;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      alive_rd_r <= alive_line_r[col_r];
    end
    if (q_push) begin
      alive_line_r[s1_col_r] <= (age_rd_r != '0);
    end
  end

  always_comb begin
    q_wdata.nbr_col = {fwd_r ? fwd_val_r : alive_rd_r, age_rd_r != '0, s1_alive_r};
    q_wdata.age     = age_rd_r;
    q_wdata.info    = s1_info_r;
  end

  `LGWA_ASSERT_NEXT(a_s1_hold, s1_v_r && q_full, s1_v_r && $stable(s1_info_r))
  `LGWA_ASSERT_IMPL(a_drain_row, drain_r, row_r >= rows_eff)

endmodule

// ----- rtl/core/lgwa_back.sv -----
// Back of the life generation core: 3x3 window, neighbor count, age update.
// Depends on lgwa_pkg and the assertion macro header; drains lgwa_queue.
`include "life_generation_with_ages_top_assert.svh"

module lgwa_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lgwa_pkg::AGE_W-1:0]  max_age,
  input  lgwa_pkg::lgwa_rec_t         q_rdata,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lgwa_pkg::AGE_W-1:0]  out_new_age,
  output logic [lgwa_pkg::ROW_W-1:0]  out_row,
  output logic [lgwa_pkg::COL_W-1:0]  out_col,
  output logic                        out_frame_done
);

  logic [2:0] w1_r, w2_r;
  logic [lgwa_pkg::AGE_W-1:0] prev_age_r;
  logic out_valid_r;
  logic [lgwa_pkg::AGE_W-1:0] out_new_age_r;
  logic [lgwa_pkg::ROW_W-1:0] out_row_r;
  logic [lgwa_pkg::COL_W-1:0] out_col_r;
  logic out_frame_done_r;

  logic out_free, load;
  logic tm, bm;
  logic [2:0] left_bits, right_bits;
  logic [3:0] cnt;
  logic grow;
  logic [lgwa_pkg::AGE_W-1:0] nage;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = !q_empty && (!q_rdata.info.emit || out_free);
  assign load     = q_pop && q_rdata.info.emit;

  assign tm         = !q_rdata.info.top_off;
  assign bm         = !q_rdata.info.bot_off;
  assign left_bits  = w2_r & {3{!q_rdata.info.left_off}} & {tm, 1'b1, bm};
  assign right_bits = q_rdata.nbr_col & {3{!q_rdata.info.right_off}} & {tm, 1'b1, bm};

  assign cnt = 4'(left_bits[2]) + 4'(left_bits[1]) + 4'(left_bits[0])
             + 4'(w1_r[2] & tm) + 4'(w1_r[0] & bm)
             + 4'(right_bits[2]) + 4'(right_bits[1]) + 4'(right_bits[0]);

  assign grow = (prev_age_r < max_age);

  always_comb begin
    case (cnt)
      lgwa_pkg::CNT_SURVIVE: begin
        nage = (grow && (prev_age_r != '0)) ? prev_age_r + lgwa_pkg::AGE_W'(1) : prev_age_r;
      end
      lgwa_pkg::CNT_BIRTH: begin
        nage = grow ? prev_age_r + lgwa_pkg::AGE_W'(1) : prev_age_r;
      end
      default: begin
        nage = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w2_r       <= w1_r;
      w1_r       <= q_rdata.nbr_col;
      prev_age_r <= q_rdata.age;
    end
    if (load) begin
      out_new_age_r    <= nage;
      out_row_r        <= q_rdata.info.row;
      out_col_r        <= q_rdata.info.col;
      out_frame_done_r <= q_rdata.info.done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_age    = out_new_age_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_done = out_frame_done_r;

  `LGWA_ASSERT_IMPL(a_done_corner, q_pop && q_rdata.info.done,
                    q_rdata.info.emit && q_rdata.info.bot_off && q_rdata.info.right_off)

endmodule

// ----- rtl/core/life_generation_with_ages_top.sv -----
// Throughput: one cell per cycle unless the queue or output stalls; after the
// last cell of a frame the input stalls while the front drains the final row.
// Order: the result for cell (r,c) is computed once the cell one row and one
// column later is accepted, passes the front's stage registers and the queue,
// and waits in the output register until out_stall is low.
// Reset (synchronous, active low): registers return to 32/32/255, counters and
// pipeline go empty; line buffers are not cleared and need no clearing pass.
module life_generation_with_ages_top #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lgwa_pkg::AGE_W-1:0]    in_cell_age,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lgwa_pkg::AGE_W-1:0]    out_new_age,
  output logic [lgwa_pkg::ROW_W-1:0]    out_row,
  output logic [lgwa_pkg::COL_W-1:0]    out_col,
  output logic                          out_frame_done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lgwa_pkg::APB_AW-1:0]   paddr,
  input  logic [lgwa_pkg::APB_DW-1:0]   pwdata,
  output logic [lgwa_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int RW  = $clog2(MAX_ROWS + 2);
  localparam int CW  = $clog2(MAX_COLS + 1);

  logic [lgwa_pkg::ROWS_REG_W-1:0] grid_rows_r;
  logic [lgwa_pkg::COLS_REG_W-1:0] grid_cols_r;
  logic [lgwa_pkg::AGE_W-1:0]      max_age_r;

  logic [1:0]  reg_idx;
  logic        wr_en, restart;
  logic [31:0] rows_full, cols_full;
  logic [RW-1:0] rows_eff;
  logic [CW-1:0] cols_eff;

  logic                q_push, q_pop, q_full, q_empty;
  lgwa_pkg::lgwa_rec_t q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign restart = wr_en && ((reg_idx == lgwa_pkg::REG_GRID_ROWS) ||
                             (reg_idx == lgwa_pkg::REG_GRID_COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= lgwa_pkg::ROWS_RESET;
      grid_cols_r <= lgwa_pkg::COLS_RESET;
      max_age_r   <= lgwa_pkg::MAX_AGE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        lgwa_pkg::REG_GRID_ROWS: grid_rows_r <= pwdata[lgwa_pkg::ROWS_REG_W-1:0];
        lgwa_pkg::REG_GRID_COLS: grid_cols_r <= pwdata[lgwa_pkg::COLS_REG_W-1:0];
        lgwa_pkg::REG_MAX_AGE:   max_age_r   <= pwdata[lgwa_pkg::AGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lgwa_pkg::REG_GRID_ROWS: prdata = lgwa_pkg::APB_DW'(grid_rows_r);
      lgwa_pkg::REG_GRID_COLS: prdata = lgwa_pkg::APB_DW'(grid_cols_r);
      lgwa_pkg::REG_MAX_AGE:   prdata = lgwa_pkg::APB_DW'(max_age_r);
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    if (grid_rows_r == '0) begin
      rows_full = 32'd1;
    end else if (32'(grid_rows_r) > 32'(MAX_ROWS)) begin
      rows_full = 32'(MAX_ROWS);
    end else begin
      rows_full = 32'(grid_rows_r);
    end
    if (grid_cols_r == '0) begin
      cols_full = 32'd1;
    end else if (32'(grid_cols_r) > 32'(MAX_COLS)) begin
      cols_full = 32'(MAX_COLS);
    end else begin
      cols_full = 32'(grid_cols_r);
    end
  end

  assign rows_eff = rows_full[RW-1:0];
  assign cols_eff = cols_full[CW-1:0];

  lgwa_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .rows_eff    (rows_eff),
    .cols_eff    (cols_eff),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cell_age (in_cell_age),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  lgwa_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  lgwa_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .max_age        (max_age_r),
    .q_rdata        (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_new_age    (out_new_age),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_done (out_frame_done)
  );

endmodule
